// ===== rtl/iis_pkg.sv =====
// Shared types and constants of the integral image stream unit.
// No dependencies.
package iis_pkg;

   localparam int PIX_W = 16;
   localparam int SUM_W = 40;
   localparam int CFG_W = 12;
   localparam int ROW_W = 11;
   localparam int HGT_W = 13;
   localparam int EXT_W = SUM_W + 3;

   localparam logic [CFG_W-1:0] SIZE_RESET = 12'd2048;
   localparam int               SIZE_MIN   = 2;
   localparam int               HEIGHT_MAX = 2048;

   localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] area_sum;
      logic                    frame_last;
   } rsp_item_type;

endpackage

// ===== rtl/integral_image_stream_unit.sv =====
// Integral image stream unit: top level with scan counters and sum stage.
// Uses iis_pkg, iis_line_mem and iis_rsp_queue.
//
// Pixels of one frame enter on the req channel in raster order, one item per
// pixel; each gives one rsp item with the summed-area value at that place and
// a flag on the last pixel of the frame. Row 0 and column 0 pass the pixel
// through; elsewhere the value is pixel + above + left - above-left,
// saturated to 40 bits signed.
// Frame size is written on the csr port (index 0 width, index 1 height) while
// the unit is idle; out-of-range sizes are clamped.
// An accepted pixel passes the stage-1 registers and then the result queue
// before rsp_valid rises. Throughput: one item per clock while req_ready
// holds, set by the single read and single write port of the line store,
// which is read at acceptance and written in the cycle after.
// Reset clears the scan position and sets both sizes to 2048; the line store
// keeps its contents, since row 0 never uses what it reads.
// When the receiver stalls, up to four results wait in the result queue;
// req_ready falls once queued plus in-flight items reach four.
module integral_image_stream_unit
   import iis_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [PIX_W-1:0]        req_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [SUM_W-1:0] rsp_area_sum,
   output logic                    rsp_frame_last,
   input  logic                    csr_wr_en,
   input  logic                    csr_index,
   input  logic [CFG_W-1:0]        csr_wdata
);

   localparam int AW      = $clog2(MAX_WIDTH);
   localparam int WRAW    = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W   = ((WRAW > CFG_W) ? WRAW : CFG_W) + 1;
   localparam int PIX_USE = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
   localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((33'd1 << PIX_USE) - 33'd1);

   logic [CFG_W-1:0] width_ff, height_ff;
   logic [AW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic             s1_pass_ff;
   logic             s1_last_ff;
   logic [AW-1:0]    s1_addr_ff;

   logic [SUM_W-1:0] left_ff, upper_left_ff;

   logic             accept;
   logic [CMP_W-1:0] width_raw, width_use, col_plus;
   logic [HGT_W-1:0] height_raw, height_use, row_plus;
   logic             row_end, frame_end;

   logic [SUM_W-1:0] above;
   logic [EXT_W-1:0] ext_sum;
   logic [SUM_W-1:0] sum_val;
   rsp_item_type     push_item, head_item;
   logic [2:0]       q_count;
   logic             rsp_pop;

   assign req_ready = ((3'(s1_valid_ff) + q_count) < 3'd4);
   assign accept    = req_valid && req_ready;

   always_comb begin
      width_raw  = CMP_W'(width_ff);
      width_use  = (width_raw < CMP_W'(SIZE_MIN)) ? CMP_W'(SIZE_MIN) :
                   (width_raw > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : width_raw;
      height_raw = HGT_W'(height_ff);
      height_use = (height_raw < HGT_W'(SIZE_MIN)) ? HGT_W'(SIZE_MIN) :
                   (height_raw > HGT_W'(HEIGHT_MAX)) ? HGT_W'(HEIGHT_MAX) : height_raw;
      col_plus   = CMP_W'(col_ff) + CMP_W'(1);
      row_plus   = HGT_W'(row_ff) + HGT_W'(1);
      row_end    = (col_plus >= width_use);
      frame_end  = row_end && (row_plus >= height_use);
      col_in     = row_end ? '0 : col_plus[AW-1:0];
      row_in     = frame_end ? '0 : (row_end ? row_plus[ROW_W-1:0] : row_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= SIZE_RESET;
         height_ff   <= SIZE_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         left_ff     <= '0;
         upper_left_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            case (reg_index_type'(csr_index))
               REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
               REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         s1_valid_ff <= accept;
         if (s1_valid_ff) begin
            left_ff       <= sum_val;
            upper_left_ff <= above;
         end
      end
      if (accept) begin
         s1_pix_ff  <= req_pixel & PIX_MASK;
         s1_pass_ff <= (row_ff == '0) || (col_ff == '0);
         s1_last_ff <= frame_end;
         s1_addr_ff <= col_ff;
      end
   end

   iis_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW),
      .DW    (SUM_W)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (sum_val),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (above)
   );

   always_comb begin
      ext_sum = EXT_W'(s1_pix_ff)
              + {{3{above[SUM_W-1]}}, above}
              + {{3{left_ff[SUM_W-1]}}, left_ff}
              - {{3{upper_left_ff[SUM_W-1]}}, upper_left_ff};
      if (s1_pass_ff) begin
         sum_val = SUM_W'(s1_pix_ff);
      end else if (ext_sum[EXT_W-1:SUM_W-1] == '0 || ext_sum[EXT_W-1:SUM_W-1] == '1) begin
         sum_val = ext_sum[SUM_W-1:0];
      end else begin
         sum_val = ext_sum[EXT_W-1] ? SUM_MIN : SUM_MAX;
      end
      push_item.area_sum   = sum_val;
      push_item.frame_last = s1_last_ff;
   end

   assign rsp_pop = rsp_valid && rsp_ready;

   iis_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (s1_valid_ff),
      .push_item  (push_item),
      .pop        (rsp_pop),
      .head_valid (rsp_valid),
      .head_item  (head_item),
      .count      (q_count)
   );

   assign rsp_area_sum   = head_item.area_sum;
   assign rsp_frame_last = head_item.frame_last;

`ifndef NO_ASSERTIONS
   a_no_rw_same_entry: assert property (@(posedge clock) disable iff (reset)
      accept && s1_valid_ff |-> col_ff != s1_addr_ff)
      else $error("line store read and write hit the same entry");
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && frame_end |=> col_ff == '0 && row_ff == '0)
      else $error("scan position not cleared after frame end");
`endif

endmodule

// ===== rtl/iis_line_mem.sv =====
// Line store of the previous row's sums: one write and one read port.
// Synchronous memory, read data registered; no dependencies.
module iis_line_mem #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11,
   parameter int DW    = 40
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/iis_rsp_queue.sv =====
// Four-entry result queue between the sum stage and the rsp channel.
// Uses iis_pkg for the result item type.
module iis_rsp_queue
   import iis_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   input  logic         pop,
   output logic         head_valid,
   output rsp_item_type head_item,
   output logic [2:0]   count
);

   localparam int DEPTH = 4;

   rsp_item_type slot_ff [DEPTH];
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [2:0]   count_ff,  count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + 3'(push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_valid = (count_ff != 3'd0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != 3'(DEPTH))
      else $error("result queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 3'd0)
      else $error("result queue underflow");
`endif

endmodule
